FILE: rtl/core/ntc_pkg.sv
// Shared types, constants and the voltage/temperature table of the NTC averager.
// Used by every module in rtl/core but ntc_divider; it depends on nothing else.
package ntc_pkg;

    localparam int CODE_W           = 12;
    localparam int REF_W            = 13;
    localparam int MAXC_W           = 12;
    localparam int VOLT_W           = 13;
    localparam int TEMP_W           = 15;

    localparam int SAMPLE_COUNT_DEF = 16;
    localparam int TABLE_POINTS_DEF = 15;
    localparam int TBL_PTS_MAX      = 15;

    localparam int SEG_W            = 4;
    localparam int MV_W             = 12;
    localparam int T16_W            = 13;
    localparam int DT_W             = 14;
    localparam int DV_W             = 14;
    localparam int TPROD_W          = DT_W + DV_W;
    // The interpolation quotient stays well below 2^22 for this table.
    localparam int TQ_W             = 22;
    localparam int TSUM_W           = 24;

    localparam int APB_ADDR_W       = 3;
    localparam int APB_DATA_W       = 32;
    localparam int S_TDATA_W        = 16;
    localparam int M_TDATA_W        = 32;

    localparam logic [VOLT_W-1:0]        VOLT_SAT   = 13'd5000;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX   = 15'sh3FFF;
    localparam logic signed [TEMP_W-1:0] TEMP_MIN   = 15'sh4000;
    localparam logic [REF_W-1:0]         REF_RESET  = 13'd3300;
    localparam logic [MAXC_W-1:0]        MAXC_RESET = 12'd4095;

    localparam logic [0:0] REG_ADC_REF_MV   = 1'b0;
    localparam logic [0:0] REG_ADC_MAX_CODE = 1'b1;

    // Table voltages in mV, falling strictly, and temperatures in 1/16 degC.
    localparam logic [MV_W-1:0] TBL_MV [TBL_PTS_MAX] = '{
        12'd2046, 12'd1653, 12'd1240, 12'd838, 12'd525, 12'd414, 12'd370, 12'd293,
        12'd245, 12'd193, 12'd173, 12'd139, 12'd119, 12'd95, 12'd84
    };
    localparam logic [T16_W-1:0] TBL_T16 [TBL_PTS_MAX] = '{
        13'd1647, 13'd1932, 13'd2244, 13'd2609, 13'd3024, 13'd3229, 13'd3328,
        13'd3525, 13'd3684, 13'd3888, 13'd3987, 13'd4165, 13'd4310, 13'd4475,
        13'd4589
    };

    typedef struct packed {
        logic accept;
        logic load_vprod;
        logic div_start;
        logic div_sel_temp;
        logic take_volt;
        logic load_seg;
        logic load_tprod;
        logic load_out;
        logic out_pop;
    } t_cmd;

    typedef struct packed {
        logic last_sample;
        logic div_done;
        logic out_valid;
    } t_sts;

    // First segment i whose lower end does not exceed v; the last segment
    // when v lies below every point. Compares are independent, then priority.
    function automatic logic [SEG_W-1:0] seg_find(input logic [VOLT_W-1:0] v,
                                                  input int npts);
        logic [SEG_W-1:0] seg;
        seg = SEG_W'(npts - 2);
        for (int i = TBL_PTS_MAX - 2; i >= 0; i--) begin
            if ((i + 2 <= npts) && (v >= {1'b0, TBL_MV[i + 1]})) begin
                seg = SEG_W'(i);
            end
        end
        return seg;
    endfunction

endpackage

FILE: rtl/core/ntc_divider.sv
// Iterative restoring divider, one quotient bit per cycle.
// Uses no package; instantiated by ntc_datapath.
module ntc_divider #(
    parameter int NUM_W = 29,
    parameter int DEN_W = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;

    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_sub;
    logic             ge;

    always_comb begin
        rem_sh  = {r_rem, r_quo[NUM_W-1]};
        ge      = rem_sh >= {1'b0, r_den};
        rem_sub = rem_sh - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[NUM_W-2:0], ge};
            r_rem <= ge ? DEN_W'(rem_sub) : DEN_W'(rem_sh);
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");

endmodule

FILE: rtl/core/ntc_datapath.sv
// Datapath of the NTC averager: sample sum, voltage scaling, segment pick,
// interpolation and output register. Depends on ntc_pkg and ntc_divider.
module ntc_datapath #(
    parameter int SAMPLE_COUNT = ntc_pkg::SAMPLE_COUNT_DEF,
    parameter int TABLE_POINTS = ntc_pkg::TABLE_POINTS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ntc_pkg::t_cmd                      i_cmd,
    input  logic [ntc_pkg::CODE_W-1:0]         i_adc_code,
    input  logic [ntc_pkg::REF_W-1:0]          i_adc_ref_mv,
    input  logic [ntc_pkg::MAXC_W-1:0]         i_adc_max_code,
    output ntc_pkg::t_sts                      o_sts,
    output logic [ntc_pkg::VOLT_W-1:0]         o_voltage_mv,
    output logic signed [ntc_pkg::TEMP_W-1:0]  o_temperature_x16
);

    localparam int SUM_W = $clog2(SAMPLE_COUNT * 4095 + 1);
    localparam int CNT_W = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
    localparam int DIV_W = SUM_W + ntc_pkg::REF_W;

    logic [SUM_W-1:0]                     r_sum;
    logic [CNT_W-1:0]                     r_idx;
    logic [DIV_W-1:0]                     r_vprod;
    logic [SUM_W-1:0]                     r_vden;
    logic [ntc_pkg::VOLT_W-1:0]           r_volt;
    logic signed [ntc_pkg::DT_W-1:0]      r_dt;
    logic signed [ntc_pkg::DV_W-1:0]      r_dv;
    logic [ntc_pkg::MV_W-1:0]             r_dd;
    logic [ntc_pkg::T16_W-1:0]            r_t2;
    logic signed [ntc_pkg::TPROD_W-1:0]   r_tprod;
    logic                                 r_out_valid;
    logic [ntc_pkg::VOLT_W-1:0]           r_out_volt;
    logic signed [ntc_pkg::TEMP_W-1:0]    r_out_temp;

    logic                                 last_sample;
    logic [ntc_pkg::MAXC_W-1:0]           maxc_eff;
    logic [ntc_pkg::SEG_W-1:0]            seg;
    logic [ntc_pkg::SEG_W-1:0]            seg_nx;
    logic [ntc_pkg::TPROD_W-1:0]          t_mag;
    logic [DIV_W-1:0]                     div_num;
    logic [SUM_W-1:0]                     div_den;
    logic                                 div_done;
    logic [DIV_W-1:0]                     div_quo;
    logic [ntc_pkg::VOLT_W-1:0]           volt_sat;
    logic signed [ntc_pkg::TSUM_W-1:0]    q_ext;
    logic signed [ntc_pkg::TSUM_W-1:0]    q_s;
    logic signed [ntc_pkg::TSUM_W-1:0]    t_sum;
    logic signed [ntc_pkg::TEMP_W-1:0]    t_sat;

    always_comb begin
        last_sample = r_idx == CNT_W'(SAMPLE_COUNT - 1);
        maxc_eff    = (i_adc_max_code == '0) ? ntc_pkg::MAXC_W'(1) : i_adc_max_code;
        seg         = ntc_pkg::seg_find(r_volt, TABLE_POINTS);
        seg_nx      = seg + ntc_pkg::SEG_W'(1);
        t_mag       = r_tprod[ntc_pkg::TPROD_W-1] ? ntc_pkg::TPROD_W'(-r_tprod)
                                                  : ntc_pkg::TPROD_W'(r_tprod);
        div_num     = i_cmd.div_sel_temp ? DIV_W'(t_mag) : r_vprod;
        div_den     = i_cmd.div_sel_temp ? SUM_W'(r_dd) : r_vden;
        volt_sat    = (div_quo > DIV_W'(ntc_pkg::VOLT_SAT)) ? ntc_pkg::VOLT_SAT
                                                          : div_quo[ntc_pkg::VOLT_W-1:0];
        // Quotient truncates toward zero: divide magnitudes, then restore sign.
        q_ext       = $signed(ntc_pkg::TSUM_W'(div_quo[ntc_pkg::TQ_W-1:0]));
        q_s         = r_tprod[ntc_pkg::TPROD_W-1] ? -q_ext : q_ext;
        t_sum       = q_s + $signed(ntc_pkg::TSUM_W'(r_t2));
        if (t_sum > ntc_pkg::TSUM_W'(ntc_pkg::TEMP_MAX)) begin
            t_sat = ntc_pkg::TEMP_MAX;
        end else if (t_sum < ntc_pkg::TSUM_W'(ntc_pkg::TEMP_MIN)) begin
            t_sat = ntc_pkg::TEMP_MIN;
        end else begin
            t_sat = ntc_pkg::TEMP_W'(t_sum);
        end
    end

    ntc_divider #(
        .NUM_W (DIV_W),
        .DEN_W (SUM_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_sum <= r_sum + SUM_W'(i_adc_code);
                r_idx <= last_sample ? '0 : r_idx + CNT_W'(1);
            end else if (i_cmd.load_vprod) begin
                r_sum <= '0;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_cmd.out_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_vprod) begin
            r_vprod <= DIV_W'(r_sum) * DIV_W'(i_adc_ref_mv);
            r_vden  <= SUM_W'(SAMPLE_COUNT) * SUM_W'(maxc_eff);
        end
        if (i_cmd.take_volt) begin
            r_volt <= volt_sat;
        end
        if (i_cmd.load_seg) begin
            r_dt <= $signed({1'b0, ntc_pkg::TBL_T16[seg]})
                  - $signed({1'b0, ntc_pkg::TBL_T16[seg_nx]});
            r_dv <= $signed({1'b0, r_volt}) - $signed({2'b00, ntc_pkg::TBL_MV[seg_nx]});
            r_dd <= ntc_pkg::TBL_MV[seg] - ntc_pkg::TBL_MV[seg_nx];
            r_t2 <= ntc_pkg::TBL_T16[seg_nx];
        end
        if (i_cmd.load_tprod) begin
            r_tprod <= r_dt * r_dv;
        end
        if (i_cmd.load_out) begin
            r_out_volt <= r_volt;
            r_out_temp <= t_sat;
        end
    end

    assign o_sts.last_sample = last_sample;
    assign o_sts.div_done    = div_done;
    assign o_sts.out_valid   = r_out_valid;
    assign o_voltage_mv      = r_out_volt;
    assign o_temperature_x16 = r_out_temp;

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> !r_out_valid)
        else $error("result loaded over an untaken result");

    a_volt_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.take_volt |=> (r_volt <= ntc_pkg::VOLT_SAT))
        else $error("voltage above saturation limit");

endmodule

FILE: rtl/core/ntc_ctrl.sv
// Sequencer of the NTC averager: input handshake, the two divisions and the
// result hand-off. Depends on ntc_pkg for the command and status types.
module ntc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    input  logic          i_m_tready,
    input  ntc_pkg::t_sts i_sts,
    output logic          o_s_tready,
    output ntc_pkg::t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_VMUL,
        S_VSTART,
        S_VWAIT,
        S_SEG,
        S_TMUL,
        S_TSTART,
        S_TWAIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   s_tready;
    logic   accept;

    always_comb begin
        s_tready = (r_state == S_IDLE) && !(i_sts.last_sample && i_sts.out_valid);
        accept   = i_s_tvalid && s_tready;
        n_state  = r_state;
        o_cmd    = '0;
        o_cmd.accept  = accept;
        o_cmd.out_pop = i_sts.out_valid && i_m_tready;
        case (r_state)
            S_IDLE: begin
                if (accept && i_sts.last_sample) begin
                    n_state = S_VMUL;
                end
            end
            S_VMUL: begin
                o_cmd.load_vprod = 1'b1;
                n_state          = S_VSTART;
            end
            S_VSTART: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_VWAIT;
            end
            S_VWAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.take_volt = 1'b1;
                    n_state         = S_SEG;
                end
            end
            S_SEG: begin
                o_cmd.load_seg = 1'b1;
                n_state        = S_TMUL;
            end
            S_TMUL: begin
                o_cmd.load_tprod = 1'b1;
                n_state          = S_TSTART;
            end
            S_TSTART: begin
                o_cmd.div_start    = 1'b1;
                o_cmd.div_sel_temp = 1'b1;
                n_state            = S_TWAIT;
            end
            S_TWAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_tready = s_tready;

    a_block_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_sts.last_sample) |=> (r_state == S_VMUL))
        else $error("last sample of a block did not start the computation");

endmodule

FILE: rtl/core/ntc_adc_average_to_temperature_core.sv
// Top level of the NTC ADC averager with piecewise-linear temperature lookup.
// Depends on ntc_pkg, ntc_ctrl, ntc_datapath and ntc_divider.
//
// Usage: raw 12-bit thermistor ADC codes arrive as transfers on the s_axis
// channel. Every SAMPLE_COUNT codes form one block; the last code of a block
// produces one result transfer on m_axis carrying the mean divider voltage in
// mV (saturated at 5000) and the temperature in 1/16 degC, interpolated in a
// fixed table of TABLE_POINTS points and saturated to 15 bits signed.
// A code that does not close a block is taken while the block is idle. After the
// closing code the block runs two iterative divisions of DIV_W = SUM_W + 13 bits
// each on the shared one-bit-per-cycle divider, and s_axis_tready stays low
// meanwhile, until the result has been loaded into the output register.
// The result is held in an output register, so codes keep being taken while it
// waits; only the code that would close the next block is held off until the
// result has been taken. A stalled receiver thus never loses a result.
// Reset clears the sum, the sample count and the output valid, and sets
// adc_ref_mv to 3300 and adc_max_code to 4095. The APB registers are meant to
// be written while the block is idle; new values apply to the next result.
module ntc_adc_average_to_temperature_core #(
    parameter int SAMPLE_COUNT = ntc_pkg::SAMPLE_COUNT_DEF,
    parameter int TABLE_POINTS = ntc_pkg::TABLE_POINTS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // s_axis_tdata: [11:0] adc_code, [15:12] zero.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [ntc_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // m_axis_tdata: [12:0] voltage_mv, [27:13] temperature_x16, [31:28] zero.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [ntc_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ntc_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [ntc_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [ntc_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    logic [ntc_pkg::REF_W-1:0]          r_adc_ref_mv;
    logic [ntc_pkg::MAXC_W-1:0]         r_adc_max_code;

    ntc_pkg::t_cmd                      cmd;
    ntc_pkg::t_sts                      sts;
    logic [ntc_pkg::VOLT_W-1:0]         voltage_mv;
    logic signed [ntc_pkg::TEMP_W-1:0]  temperature_x16;
    logic                               cfg_write;

    // Register index is address bit 2; the low two address bits select a
    // byte within the word and are ignored.
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adc_ref_mv   <= ntc_pkg::REF_RESET;
            r_adc_max_code <= ntc_pkg::MAXC_RESET;
        end else if (cfg_write) begin
            case (paddr[2])
                ntc_pkg::REG_ADC_REF_MV: begin
                    r_adc_ref_mv <= pwdata[ntc_pkg::REF_W-1:0];
                end
                ntc_pkg::REG_ADC_MAX_CODE: begin
                    r_adc_max_code <= pwdata[ntc_pkg::MAXC_W-1:0];
                end
                default: begin
                    r_adc_ref_mv <= r_adc_ref_mv;
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            ntc_pkg::REG_ADC_REF_MV:   prdata = ntc_pkg::APB_DATA_W'(r_adc_ref_mv);
            ntc_pkg::REG_ADC_MAX_CODE: prdata = ntc_pkg::APB_DATA_W'(r_adc_max_code);
            default:                   prdata = '0;
        endcase
    end

    ntc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_sts      (sts),
        .o_s_tready (s_axis_tready),
        .o_cmd      (cmd)
    );

    ntc_datapath #(
        .SAMPLE_COUNT (SAMPLE_COUNT),
        .TABLE_POINTS (TABLE_POINTS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_adc_code        (s_axis_tdata[ntc_pkg::CODE_W-1:0]),
        .i_adc_ref_mv      (r_adc_ref_mv),
        .i_adc_max_code    (r_adc_max_code),
        .o_sts             (sts),
        .o_voltage_mv      (voltage_mv),
        .o_temperature_x16 (temperature_x16)
    );

    assign m_axis_tvalid = sts.out_valid;
    assign m_axis_tdata  = {
        {(ntc_pkg::M_TDATA_W - ntc_pkg::TEMP_W - ntc_pkg::VOLT_W){1'b0}},
        temperature_x16,
        voltage_mv
    };

endmodule
